// ----- src/binary_to_decimal_ascii_top_assert.svh -----
// Assertion macros shared by the converter modules.
// Each expects clk and rst_n in the enclosing module.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/b2da_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package b2da_pkg;

  localparam int BIN_W          = 32;
  localparam int SGN_W          = 16;
  localparam int BIT_CNT_W      = $clog2(BIN_W);
  localparam int MAX_DIGITS_DEF = 10;
  localparam int CHAR_W         = 7;
  localparam int TDATA_OUT_W    = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
    logic sel_sign;
  } b2da_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic digit_last;
    logic neg;
  } b2da_sts_t;

endpackage

`default_nettype wire

// ----- src/b2da_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_ascii_top_assert.svh"

module b2da_datapath #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire b2da_pkg::b2da_cmd_t           cmd,
  output      b2da_pkg::b2da_sts_t           sts,
  input  wire logic [b2da_pkg::BIN_W-1:0]    in_number,
  input  wire logic                          in_is_signed,
  output      logic [b2da_pkg::CHAR_W-1:0]   character
);
  import b2da_pkg::*;

  localparam int BCD_W  = 4 * MAX_DIGITS;
  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

  logic [BIN_W-1:0]     bin_r, bin_nxt;
  logic [BCD_W-1:0]     bcd_r, bcd_nxt, bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [DCNT_W-1:0]    dig_cnt_r, dig_cnt_nxt;
  logic                 neg_r, neg_nxt;
  logic [SGN_W-1:0]     v16;
  logic [SGN_W:0]       mag_s;
  logic [BIN_W-1:0]     mag;
  logic                 mag_neg;
  logic [3:0]           top_digit;

  // Form the magnitude; a negative 16-bit value is negated in 17 bits
  always_comb begin
    v16     = in_number[SGN_W-1:0];
    mag_s   = {1'b1, {SGN_W{1'b0}}} - {1'b0, v16};
    mag_neg = in_is_signed && v16[SGN_W-1];
    if (mag_neg) begin
      mag = BIN_W'(mag_s);
    end else if (in_is_signed) begin
      mag = BIN_W'(v16);
    end else begin
      mag = in_number;
    end
  end

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd_r[4*d +: 4] >= 4'd5) ? bcd_r[4*d +: 4] + 4'd3
                                                     : bcd_r[4*d +: 4];
    end
  end

  // Next values of the datapath registers
  always_comb begin
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    neg_nxt     = neg_r;
    priority if (cmd.load) begin
      bin_nxt     = mag;
      bcd_nxt     = '0;
      bit_cnt_nxt = '0;
      dig_cnt_nxt = DCNT_W'(MAX_DIGITS);
      neg_nxt     = mag_neg;
    end else if (cmd.dabble) begin
      bin_nxt     = {bin_r[BIN_W-2:0], 1'b0};
      bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[BIN_W-1]};
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end else if (cmd.shift_digit) begin
      bcd_nxt     = {bcd_r[BCD_W-5:0], 4'h0};
      dig_cnt_nxt = dig_cnt_r - 1'b1;
    end else begin
      // hold everything
      bin_nxt     = bin_r;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    if (!rst_n) begin
      bit_cnt_r <= '0;
      dig_cnt_r <= DCNT_W'(MAX_DIGITS);
      neg_r     <= 1'b0;
    end else begin
      bit_cnt_r <= bit_cnt_nxt;
      dig_cnt_r <= dig_cnt_nxt;
      neg_r     <= neg_nxt;
    end
  end

  // Status, and the character of the leading digit or the minus sign
  assign top_digit      = bcd_r[BCD_W-1 -: 4];
  assign sts.conv_last  = (bit_cnt_r == BIT_CNT_W'(BIN_W - 1));
  assign sts.top_zero   = (top_digit == 4'h0);
  assign sts.digit_last = (dig_cnt_r == DCNT_W'(1));
  assign sts.neg        = neg_r;
  assign character      = cmd.sel_sign ? ASCII_MINUS
                                       : ASCII_ZERO + CHAR_W'(top_digit);

  `B2DA_ASSERT_NOW(dp_keep_last_digit, cmd.shift_digit, dig_cnt_r > DCNT_W'(1), "shift past last digit")
  `B2DA_ASSERT_NOW(dp_digit_cnt_live, 1'b1, dig_cnt_r != '0, "digit count reached zero")
  `B2DA_ASSERT_NEXT(dp_load_clear, cmd.load, (bcd_r == '0) && (bit_cnt_r == '0), "load left digits set")

endmodule

`default_nettype wire

// ----- src/b2da_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_ascii_top_assert.svh"

module b2da_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output      logic                 in_tready,
  output      logic                 out_tvalid,
  input  wire logic                 out_tready,
  output      logic                 out_tlast,
  output      b2da_pkg::b2da_cmd_t  cmd,
  input  wire b2da_pkg::b2da_sts_t  sts
);
  import b2da_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_SKIP  = 5'b00100,
    S_SIGN  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Handshake outputs follow the state
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_SIGN) || (state_r == S_DIGIT);
  assign out_tlast  = (state_r == S_DIGIT) && sts.digit_last;

  // Commands to the datapath
  assign cmd.load        = (state_r == S_IDLE) && in_tvalid;
  assign cmd.dabble      = (state_r == S_CONV);
  assign cmd.shift_digit = ((state_r == S_SKIP) && sts.top_zero && !sts.digit_last) ||
                           ((state_r == S_DIGIT) && out_tready && !sts.digit_last);
  assign cmd.sel_sign    = (state_r == S_SIGN);

  // Advance through convert, skip leading zeros, sign, digits
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_CONV;
      end
      S_CONV: begin
        if (sts.conv_last) state_nxt = S_SKIP;
      end
      S_SKIP: begin
        if (!sts.top_zero || sts.digit_last) begin
          state_nxt = sts.neg ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_tready) state_nxt = S_DIGIT;
      end
      S_DIGIT: begin
        if (out_tready && sts.digit_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `B2DA_ASSERT_NEXT(ctl_accept_conv, in_tvalid && in_tready, state_r == S_CONV, "accept did not start conversion")
  `B2DA_ASSERT_NEXT(ctl_conv_done, (state_r == S_CONV) && sts.conv_last, state_r == S_SKIP, "conversion overran")
  `B2DA_ASSERT_NEXT(ctl_final_idle, out_tvalid && out_tready && out_tlast, state_r == S_IDLE, "no idle after last")

endmodule

`default_nettype wire

// ----- src/binary_to_decimal_ascii_top.sv -----
// Sequence: the number is accepted, then converted by double dabble, then each
// suppressed leading zero (up to MAX_DIGITS-1) is skipped before the first character
// is offered. Throughput: one character per cycle while out_tready is high; the
// block handles one number at a time.
// Reset (synchronous, rst_n low) returns the controller to idle and resets counters.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_ascii_top #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  input  wire logic [b2da_pkg::BIN_W-1:0]         in_tdata,   // [31:0] number
  input  wire logic                               in_tuser,   // [0] is_signed
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  output      logic [b2da_pkg::TDATA_OUT_W-1:0]   out_tdata,  // [6:0] character, [7] zero
  output      logic                               out_tlast
);
  import b2da_pkg::*;

  b2da_cmd_t         cmd;
  b2da_sts_t         sts;
  logic [CHAR_W-1:0] character;

  b2da_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  b2da_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_number    (in_tdata),
    .in_is_signed (in_tuser),
    .character    (character)
  );

  // Pad the character to a whole byte
  assign out_tdata = {{(TDATA_OUT_W - CHAR_W){1'b0}}, character};

endmodule

`default_nettype wire

// ----- sim/decimal_char_checker.sv -----
`timescale 1ns / 1ps

// Watch both channels of the converter, work out the characters each accepted
// number should print and compare every character transfer against them.
module decimal_char_checker #(
  parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [b2da_pkg::BIN_W-1:0]        in_tdata,   // [31:0] number
  input  logic                              in_tuser,   // [0] is_signed
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [b2da_pkg::TDATA_OUT_W-1:0]  out_tdata,  // [6:0] character, [7] zero
  input  logic                              out_tlast,
  output int                                fail_count,
  output int                                pending_chars
);

  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] code;
    logic                        last;
  } dec_char_t;

  // characters still owed by the block, oldest first
  dec_char_t expected_chars[$];

  initial begin
    fail_count    = 0;
    pending_chars = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Append the decimal characters of one number, most significant first
  function automatic void queue_decimal(input logic [31:0] number, input logic is_signed);
    logic [31:0] magnitude;
    logic        negative;
    logic [3:0]  digit_lsf [0:31];
    int          ndig;
    dec_char_t   c;
    negative  = 1'b0;
    magnitude = number;
    ndig      = 0;
    // signed mode: low half as two's complement, magnitude in 17 bits
    if (is_signed) begin
      magnitude = {16'h0, number[15:0]};
      if (number[15]) begin
        negative  = 1'b1;
        magnitude = (32'h0001_0000 - {16'h0, number[15:0]}) & 32'h0001_FFFF;
      end
    end
    // split into digits, keeping only as many as there are digit cells
    while (magnitude != 0 && ndig < MAX_DIGITS && ndig < 32) begin
      digit_lsf[ndig] = 4'(magnitude % 10);
      magnitude       = magnitude / 10;
      ndig++;
    end
    // drop leading zeros left over from wrapping
    while (ndig > 0 && digit_lsf[ndig-1] == 4'd0) ndig--;
    if (negative) begin
      c.code = b2da_pkg::ASCII_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    if (ndig == 0) begin
      c.code = b2da_pkg::ASCII_ZERO;
      c.last = 1'b1;
      expected_chars.push_back(c);
    end else begin
      for (int i = ndig - 1; i >= 0; i--) begin
        c.code = b2da_pkg::ASCII_ZERO + 7'(digit_lsf[i]);
        c.last = (i == 0);
        expected_chars.push_back(c);
      end
    end
  endfunction

  // Predict on each number transfer, check on each character transfer
  always @(posedge clk) begin
    dec_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) queue_decimal(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("char 0x%02h last %0b with nothing expected",
                                    out_tdata, out_tlast));
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata !== {1'b0, want.code})
            report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                      out_tdata, {1'b0, want.code}));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
                                      out_tlast, want.last, {1'b0, want.code}));
        end
      end
      pending_chars = expected_chars.size();
    end
  end

endmodule

// ----- sim/binary_to_decimal_ascii_top_test.sv -----
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top_test;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  logic        in_taken   = 1'b0;
  logic        out_taken  = 1'b0;
  logic        no_idle    = 1'b0;
  int          stall_left = 0;
  int          fail_count;
  int          pending_chars;

  always #5 clk = ~clk;

  binary_to_decimal_ascii_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  decimal_char_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_chars (pending_chars)
  );

  // Record which transfers happened at each rising edge
  always @(posedge clk) begin
    in_taken  <= in_tvalid && in_tready;
    out_taken <= out_tvalid && out_tready;
  end

  // Stall the character side for a random stretch of offered cycles per character, with no stall while no_idle is set
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) stall_left = no_idle ? 0 : $urandom_range(0, 3);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        if (out_tvalid) stall_left--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Offer one number after a random gap and hold it until the transfer
  task automatic send_number(input logic [31:0] number, input logic is_signed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = number;
    in_tuser  = is_signed;
    do @(negedge clk); while (!in_taken);
  endtask

  // Mix of full-range values, small values, powers of ten or one below, 16-bit edges and shifted random values
  function automatic logic [31:0] pick_operand();
    logic [31:0] p;
    int          k;
    p = 32'd1;
    k = $urandom_range(0, 9);
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 99);
      2: begin
        repeat (k) p = p * 10;
        return p - $urandom_range(0, 1);
      end
      3: begin
        case ($urandom_range(0, 2))
          0: return {16'($urandom()), 16'h8000 + 16'($urandom_range(0, 15))};
          1: return {16'($urandom()), 16'hFFFF - 16'($urandom_range(0, 15))};
          default: return {16'($urandom()), 16'h7FFF - 16'($urandom_range(0, 15))};
        endcase
      end
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // unsigned edges and digit-count boundaries
    send_number(32'd0, 1'b0);
    send_number(32'd1, 1'b0);
    send_number(32'd9, 1'b0);
    send_number(32'd10, 1'b0);
    send_number(32'd99, 1'b0);
    send_number(32'd100, 1'b0);
    send_number(32'd999_999_999, 1'b0);
    send_number(32'd1_000_000_000, 1'b0);
    send_number(32'd1_234_567_890, 1'b0);
    send_number(32'h8000_0000, 1'b0);
    send_number(32'hFFFF_FFFF, 1'b0);
    // signed: zero, both ends of the range, minus one, and ignored upper bits
    send_number(32'h0000_0000, 1'b1);
    send_number(32'h0000_0001, 1'b1);
    send_number(32'h0000_FFFF, 1'b1);
    send_number(32'h0000_7FFF, 1'b1);
    send_number(32'h0000_8000, 1'b1);
    send_number(32'h0000_FFF6, 1'b1);
    send_number(32'h0000_000A, 1'b1);
    send_number(32'hFFFF_0000, 1'b1);
    send_number(32'hABCD_8000, 1'b1);
    send_number(32'h1234_0005, 1'b1);
    send_number(32'hFFFF_7FFF, 1'b1);

    // random numbers, with back-to-back stretches now and then
    for (int i = 0; i < 380; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_number(pick_operand(), 1'($urandom_range(0, 1)));
    end
    in_tvalid = 1'b0;
    no_idle   = 1'b0;

    // drain, then give the block time to show any stray character
    while (pending_chars != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
